>>> sv/pss_pkg.sv
// package for the path string sanitizer
// word types, command and status structs, hold buffer sizing, character constants and status codes
// no dependencies
`default_nettype none
package pss_pkg;

  localparam int HOLD_DEPTH = 32;
  localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BAD_UTF8 = 3'd2;
  localparam logic [2:0] ST_NUL      = 3'd3;
  localparam logic [2:0] ST_WS_ONLY  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_path;
  } pss_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       status_valid;
    logic [2:0] status_code;
    logic       run_last;
  } pss_out_t;

  typedef struct packed {
    logic load;
    logic emit_hold;
    logic emit_byte;
    logic emit_status;
  } pss_cmd_t;

  typedef struct packed {
    logic in_content;
    logic in_end;
    logic item_end;
    logic hold_empty;
    logic flush_last;
    logic slot_free;
  } pss_sts_t;

endpackage
`default_nettype wire

>>> sv/pss_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module pss_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/pss_ctrl.sv
// controller of the path string sanitizer: sequences accept, flush, byte and status
// depends on pss_pkg
`default_nettype none
module pss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pss_pkg::pss_sts_t sts,
  output pss_pkg::pss_cmd_t      cmd
);
  import pss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH_RD,
    S_FLUSH_EMIT,
    S_BYTE,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    in_ready        = (state_r == S_IDLE);
    cmd             = '0;
    state_nxt       = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          if (sts.in_content) begin
            state_nxt = sts.hold_empty ? S_BYTE : S_FLUSH_RD;
          end else if (sts.in_end) begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_FLUSH_RD: begin
        state_nxt = S_FLUSH_EMIT;
      end
      S_FLUSH_EMIT: begin
        cmd.emit_hold = sts.slot_free;
        if (sts.slot_free) begin
          state_nxt = sts.flush_last ? S_BYTE : S_FLUSH_RD;
        end
      end
      S_BYTE: begin
        cmd.emit_byte = sts.slot_free;
        if (sts.slot_free) begin
          state_nxt = sts.item_end ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        cmd.emit_status = sts.slot_free;
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/pss_dp.sv
// datapath of the path string sanitizer: path flags, whitespace hold buffer,
// utf-8 tracking and the output register; depends on pss_pkg and pss_ram
`default_nettype none
module pss_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pss_pkg::pss_in_t  in_data,
  output pss_pkg::pss_out_t      out_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire pss_pkg::pss_cmd_t cmd,
  output pss_pkg::pss_sts_t      sts
);
  import pss_pkg::*;

  logic               convert_r;
  logic [1:0]         cont_r;
  logic               err_r, nul_r, ovf_r, any_r, content_r;
  logic [HOLD_CW-1:0] count_r;
  logic [HOLD_CW-1:0] idx_r;
  logic [7:0]         byte_r;
  logic               end_r;
  logic               out_valid_r;
  pss_out_t           out_r;

  logic               in_ws, hold_full, hold_we, hold_kind;
  logic [2:0]         code;
  logic [7:0]         conv_byte;
  logic [HOLD_CW-1:0] idx_inc;

  assign in_ws     = (in_data.data_byte == CHAR_SPACE) || (in_data.data_byte == CHAR_TAB);
  assign hold_full = (count_r == HOLD_CW'(HOLD_DEPTH));
  assign hold_we   = cmd.load && in_data.byte_present && in_ws && content_r && !hold_full;
  assign idx_inc   = idx_r + 1'b1;

  pss_ram #(
    .WIDTH(1),
    .DEPTH(HOLD_DEPTH)
  ) u_hold (
    .clk  (clk),
    .we   (hold_we),
    .waddr(count_r[HOLD_AW-1:0]),
    .wdata(in_data.data_byte == CHAR_TAB),
    .raddr(idx_r[HOLD_AW-1:0]),
    .rdata(hold_kind)
  );

  always_comb begin
    sts.in_content = in_data.byte_present && !in_ws;
    sts.in_end     = in_data.end_of_path;
    sts.item_end   = end_r;
    sts.hold_empty = (count_r == '0);
    sts.flush_last = (idx_inc == count_r);
    sts.slot_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    if (!any_r) begin
      code = ST_EMPTY;
    end else if (err_r || (cont_r != 2'd0)) begin
      code = ST_BAD_UTF8;
    end else if (nul_r) begin
      code = ST_NUL;
    end else if (!content_r) begin
      code = ST_WS_ONLY;
    end else if (ovf_r) begin
      code = ST_OVERFLOW;
    end else begin
      code = ST_OK;
    end
  end

  assign conv_byte = (convert_r && byte_r == CHAR_BACKSLASH) ? CHAR_SLASH : byte_r;

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_r <= 1'b1;
      cont_r    <= 2'd0;
      err_r     <= 1'b0;
      nul_r     <= 1'b0;
      ovf_r     <= 1'b0;
      any_r     <= 1'b0;
      content_r <= 1'b0;
      count_r   <= '0;
      idx_r     <= '0;
    end else begin
      if (cfg_we) begin
        convert_r <= cfg_wdata;
      end
      if (cmd.load && in_data.byte_present) begin
        any_r <= 1'b1;
        if (in_data.data_byte == CHAR_NUL) begin
          nul_r <= 1'b1;
        end
        if (cont_r != 2'd0) begin
          if (in_data.data_byte[7:6] == 2'b10) begin
            cont_r <= cont_r - 2'd1;
          end else begin
            err_r  <= 1'b1;
            cont_r <= 2'd0;
          end
        end else if (!in_data.data_byte[7]) begin
          cont_r <= 2'd0;
        end else if (in_data.data_byte[7:5] == 3'b110) begin
          cont_r <= 2'd1;
        end else if (in_data.data_byte[7:4] == 4'b1110) begin
          cont_r <= 2'd2;
        end else if (in_data.data_byte[7:3] == 5'b11110) begin
          cont_r <= 2'd3;
        end else begin
          err_r <= 1'b1;
        end
        if (in_ws && content_r) begin
          if (hold_full) begin
            ovf_r <= 1'b1;
          end else begin
            count_r <= count_r + 1'b1;
          end
        end
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.emit_hold) begin
        idx_r <= idx_inc;
      end
      if (cmd.emit_byte) begin
        count_r   <= '0;
        content_r <= 1'b1;
      end
      if (cmd.emit_status) begin
        cont_r    <= 2'd0;
        err_r     <= 1'b0;
        nul_r     <= 1'b0;
        ovf_r     <= 1'b0;
        any_r     <= 1'b0;
        content_r <= 1'b0;
        count_r   <= '0;
      end
    end
  end

  // latched item and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_hold || cmd.emit_byte || cmd.emit_status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data.data_byte;
      end_r  <= in_data.end_of_path;
    end
    if (cmd.emit_hold) begin
      out_r.out_byte       <= hold_kind ? CHAR_TAB : CHAR_SPACE;
      out_r.out_byte_valid <= 1'b1;
      out_r.status_valid   <= 1'b0;
      out_r.status_code    <= ST_OK;
      out_r.run_last       <= 1'b0;
    end else if (cmd.emit_byte) begin
      out_r.out_byte       <= conv_byte;
      out_r.out_byte_valid <= 1'b1;
      out_r.status_valid   <= 1'b0;
      out_r.status_code    <= ST_OK;
      out_r.run_last       <= !end_r;
    end else if (cmd.emit_status) begin
      out_r.out_byte       <= 8'h00;
      out_r.out_byte_valid <= 1'b0;
      out_r.status_valid   <= 1'b1;
      out_r.status_code    <= code;
      out_r.run_last       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> sv/path_string_sanitizer_top.sv
// Path string sanitizer. One input word carries one path byte (or none) and an
// end-of-path flag; result words are sanitized bytes followed, at the end of a
// path, by one status word. A content byte first releases every held space or
// tab from the hold buffer, each through a ram read state and an output load
// state, and then loads its own result; a whitespace byte, held or dropped,
// leaves the controller idle. The end of a path adds a state for the status
// word. Each output load waits until the output register is free. All of this runs in
// the controller state machine, one word at a time; a new word is taken as
// soon as it is idle, even while the last result still waits in the output
// register. Byte results are tentative until the status reports ok.
// Depends on pss_pkg, pss_ctrl, pss_dp and pss_ram.
`default_nettype none
module path_string_sanitizer_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pss_pkg::pss_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pss_pkg::pss_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata
);
  import pss_pkg::*;

  pss_cmd_t cmd;
  pss_sts_t sts;

  pss_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pss_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire

>>> verif/pss_result_checker.sv
// result checker for the path string sanitizer: predicts every result word from
// the accepted input words and the backslash setting, and compares in order
// depends on pss_pkg
`timescale 1ns / 100ps
module pss_result_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire pss_pkg::pss_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire pss_pkg::pss_out_t out_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);
  import pss_pkg::*;

  logic                  convert_bs;
  logic [1:0]            cont_left;
  logic                  utf8_bad;
  logic                  nul_hit;
  logic                  ovf_hit;
  logic                  any_byte;
  logic                  content_hit;
  logic [HOLD_DEPTH-1:0] hold_tab;
  logic [HOLD_CW-1:0]    hold_cnt;
  pss_out_t              sanitized_q[$];
  pss_out_t              want;

  task automatic report(input string msg);
    fail_count++;
    $display("[chk] %0t: %s", $time, msg);
  endtask

  task automatic clear_path();
    cont_left   = '0;
    utf8_bad    = 1'b0;
    nul_hit     = 1'b0;
    ovf_hit     = 1'b0;
    any_byte    = 1'b0;
    content_hit = 1'b0;
    hold_tab    = '0;
    hold_cnt    = '0;
  endtask

  task automatic push_result(input logic [7:0] b, input logic bv, input logic sv,
                             input logic [2:0] code, input logic last);
    pss_out_t r;
    r.out_byte       = b;
    r.out_byte_valid = bv;
    r.status_valid   = sv;
    r.status_code    = code;
    r.run_last       = last;
    sanitized_q.push_back(r);
  endtask

  task automatic check_utf8(input logic [7:0] b);
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cont_left = cont_left - 2'd1;
      end else begin
        utf8_bad  = 1'b1;
        cont_left = '0;
      end
    end else if (b[7] == 1'b0) begin
      cont_left = '0;
    end else if (b[7:5] == 3'b110) begin
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cont_left = 2'd3;
    end else begin
      utf8_bad = 1'b1;
    end
  endtask

  task automatic sanitize_word(input pss_in_t w);
    logic [7:0] b;
    logic [7:0] ob;
    logic [2:0] code;
    int         i;
    b = w.data_byte;
    if (w.byte_present) begin
      any_byte = 1'b1;
      check_utf8(b);
      if (b == CHAR_NUL) nul_hit = 1'b1;
      if (b == CHAR_SPACE || b == CHAR_TAB) begin
        if (content_hit) begin
          if (hold_cnt < HOLD_DEPTH) begin
            hold_tab[hold_cnt[HOLD_AW-1:0]] = (b == CHAR_TAB);
            hold_cnt = hold_cnt + 1'b1;
          end else begin
            ovf_hit = 1'b1;
          end
        end
      end else begin
        for (i = 0; i < hold_cnt; i++)
          push_result(hold_tab[i[HOLD_AW-1:0]] ? CHAR_TAB : CHAR_SPACE,
                      1'b1, 1'b0, ST_OK, 1'b0);
        hold_cnt = '0;
        ob = (convert_bs && b == CHAR_BACKSLASH) ? CHAR_SLASH : b;
        push_result(ob, 1'b1, 1'b0, ST_OK, !w.end_of_path);
        content_hit = 1'b1;
      end
    end
    if (w.end_of_path) begin
      if (cont_left != 0) utf8_bad = 1'b1;
      if (!any_byte)         code = ST_EMPTY;
      else if (utf8_bad)     code = ST_BAD_UTF8;
      else if (nul_hit)      code = ST_NUL;
      else if (!content_hit) code = ST_WS_ONLY;
      else if (ovf_hit)      code = ST_OVERFLOW;
      else                   code = ST_OK;
      push_result(8'h00, 1'b0, 1'b1, code, 1'b1);
      clear_path();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      convert_bs = 1'b1;
      clear_path();
      sanitized_q.delete();
    end else begin
      if (cfg_we) convert_bs = cfg_wdata;
      if (in_valid && in_ready) sanitize_word(in_data);
      if (out_valid && out_ready) begin
        if (sanitized_q.size() == 0) begin
          report($sformatf("result word %h with nothing predicted", out_data));
        end else begin
          want = sanitized_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report($sformatf("out_byte %h, predicted %h", out_data.out_byte, want.out_byte));
          if (out_data.out_byte_valid !== want.out_byte_valid)
            report($sformatf("out_byte_valid %b, predicted %b",
                             out_data.out_byte_valid, want.out_byte_valid));
          if (out_data.status_valid !== want.status_valid)
            report($sformatf("status_valid %b, predicted %b",
                             out_data.status_valid, want.status_valid));
          if (out_data.status_code !== want.status_code)
            report($sformatf("status_code %0d, predicted %0d",
                             out_data.status_code, want.status_code));
          if (out_data.run_last !== want.run_last)
            report($sformatf("run_last %b, predicted %b", out_data.run_last, want.run_last));
          checked++;
        end
      end
    end
    pending <= sanitized_q.size();
  end

endmodule

>>> verif/tb.sv
// testbench top for the path string sanitizer: directed and random paths with
// bursty input, patterned output stalls and backslash setting changes
// depends on pss_pkg, path_string_sanitizer_top and pss_result_checker
`timescale 1ns / 100ps
module tb;
  import pss_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    P_NORMAL, P_LONG_WS, P_BROKEN, P_NUL, P_WS_ONLY, P_EMPTY, P_NOISE
  } path_kind_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pss_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pss_out_t out_data;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b1;

  int fail_count;
  int pending;
  int checked;
  int words_sent;
  int bytes_sent;
  int paths_sent;
  int burst_left;
  int idle_cycles;
  int next_forced;
  int stall_age;
  logic [15:0] stall_pat;
  logic [7:0]  path_q[$];

  path_string_sanitizer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pss_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] next_stall_pattern();
    case ($urandom_range(0, 4))
      0, 1: return 16'hFFFF;
      2: return 16'($urandom) | 16'h0001;
      3: return 16'($urandom & $urandom) | 16'h0001;
      default: return 16'h8000;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_pat <= 16'hFFFF;
      stall_age <= 0;
    end else begin
      out_ready <= stall_pat[0];
      if (stall_age == 0) begin
        stall_pat <= next_stall_pattern();
        stall_age <= $urandom_range(50, 300);
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
        stall_age <= stall_age - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic present, input logic last);
    pss_in_t w;
    w.data_byte    = b;
    w.byte_present = present;
    w.end_of_path  = last;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (present || last) words_sent++;
    if (present) bytes_sent++;
    if (last) paths_sent++;
  endtask

  task automatic send_path(input logic split_end);
    int i;
    for (i = 0; i < path_q.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'h00, 1'b0, 1'b0);
      send_word(path_q[i], 1'b1, (i == path_q.size() - 1) && !split_end);
    end
    if (path_q.size() == 0 || split_end) send_word(8'h00, 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_convert(input logic v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_ws(input int n);
    repeat (n) path_q.push_back($urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE);
  endtask

  task automatic add_content(input int units);
    logic [7:0] c;
    repeat (units) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: path_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
        4: path_q.push_back(CHAR_SLASH);
        5: path_q.push_back(CHAR_BACKSLASH);
        6: begin
          path_q.push_back({3'b110, 5'($urandom)});
          path_q.push_back({2'b10, 6'($urandom)});
        end
        7: begin
          path_q.push_back({4'b1110, 4'($urandom)});
          repeat (2) path_q.push_back({2'b10, 6'($urandom)});
        end
        8: begin
          path_q.push_back({5'b11110, 3'($urandom)});
          repeat (3) path_q.push_back({2'b10, 6'($urandom)});
        end
        default: begin
          c = 8'($urandom_range(1, 127));
          path_q.push_back((c == CHAR_SPACE || c == CHAR_TAB) ? 8'h7A : c);
        end
      endcase
    end
  endtask

  task automatic add_normal_body();
    add_ws($urandom_range(0, 3));
    repeat ($urandom_range(1, 6)) begin
      add_content($urandom_range(1, 4));
      add_ws($urandom_range(0, 4));
    end
  endtask

  task automatic make_path(input path_kind_t kind);
    int pos;
    path_q.delete();
    case (kind)
      P_NORMAL: add_normal_body();
      P_LONG_WS: begin
        add_content($urandom_range(1, 3));
        case ($urandom_range(0, 2))
          0: add_ws(HOLD_DEPTH);
          1: add_ws(HOLD_DEPTH + 1);
          default: add_ws($urandom_range(20, 40));
        endcase
        if ($urandom_range(0, 3) != 0) add_content($urandom_range(1, 2));
      end
      P_BROKEN: begin
        add_normal_body();
        pos = $urandom_range(0, path_q.size());
        case ($urandom_range(0, 3))
          0: path_q.insert(pos, {2'b10, 6'($urandom)});
          1: path_q.insert(pos, 8'($urandom_range(8'hF8, 8'hFF)));
          2: begin
            path_q.insert(pos, 8'h71);
            path_q.insert(pos, {3'b110, 5'($urandom)});
          end
          default: path_q.push_back({4'b1110, 4'($urandom)});
        endcase
      end
      P_NUL: begin
        add_normal_body();
        path_q.insert($urandom_range(0, path_q.size()), CHAR_NUL);
      end
      P_WS_ONLY: add_ws($urandom_range(1, 6));
      P_EMPTY: ;
      default: repeat ($urandom_range(1, 8)) path_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic run_random(input int target);
    int start;
    int pick;
    path_kind_t kind;
    start = words_sent;
    while (words_sent - start < target) begin
      if (next_forced <= P_NOISE) begin
        kind = path_kind_t'(next_forced);
        next_forced++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 52)      kind = P_NORMAL;
        else if (pick < 60) kind = P_LONG_WS;
        else if (pick < 70) kind = P_BROKEN;
        else if (pick < 75) kind = P_NUL;
        else if (pick < 80) kind = P_WS_ONLY;
        else if (pick < 84) kind = P_EMPTY;
        else                kind = P_NOISE;
      end
      make_path(kind);
      send_path($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed paths with backslash conversion at its reset setting
    path_q = '{};
    send_path(1'b1);
    path_q = '{CHAR_SPACE, CHAR_TAB, 8'h61, CHAR_BACKSLASH, CHAR_SPACE, CHAR_TAB, 8'h62, CHAR_TAB};
    send_path(1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    path_q = '{8'h78, CHAR_NUL};
    send_path(1'b1);
    path_q = '{8'hFF};
    send_path(1'b0);
    path_q = '{8'h80};
    send_path(1'b0);
    path_q = '{8'hC3, 8'h7F};
    send_path(1'b0);
    path_q = '{8'hE2, 8'h82};
    send_path(1'b0);
    path_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_path(1'b0);
    path_q = '{CHAR_SPACE, CHAR_TAB};
    send_path(1'b0);

    write_convert(1'b0);
    run_random(150);
    write_convert(1'b1);
    run_random(130);
    write_convert(1'b0);
    run_random(130);
    wait_drained();

    $display("sent %0d paths in %0d words (%0d bytes), %0d result words checked",
             paths_sent, words_sent, bytes_sent, checked);
    $display("backslash conversion ran on, off, on and off again; all path kinds mixed in");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
